// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define TQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tq_pkg.sv =====
package tq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_PAYLOAD = 4;
    localparam int OUT_BYTES = 4;
    localparam logic [2:0] PAYLOAD_LIMIT =
        3'((MAX_PAYLOAD < OUT_BYTES) ? MAX_PAYLOAD : OUT_BYTES);

    localparam int IN_DATA_W = 112;
    localparam int OUT_DATA_W = 48;

    // Request operations
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_CTS = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_ACK = 2'd0;
    localparam logic [1:0] KIND_SENT = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    typedef struct packed {
        logic            operation;
        logic [31:0]     now_ms;
        logic [7:0]      msg_type;
        logic [31:0]     send_time;
        logic [2:0]      payload_length;
        logic [3:0][7:0] payload_bytes;
    } req_t;

    typedef struct packed {
        logic [31:0]     send_time;
        logic [7:0]      msg_type;
        logic [2:0]      length;
        logic [3:0][7:0] payload;
    } entry_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic            dropped;
        logic [7:0]      out_type;
        logic [2:0]      out_length;
        logic [3:0][7:0] out_bytes;
    } result_t;

endpackage

// ===== sv/timed_transmit_queue.sv =====
// Timed transmit queue with drop-oldest overflow.
// Requests enter on the s_ channel: s_tuser selects enqueue (0) or clear to send (1),
// s_tdata carries the time and message fields. Every request yields exactly one
// result on the m_ channel, with the result kind in m_tuser.
// An enqueue appends the message; when the queue is full the oldest entry is
// overwritten and the result flags the drop. Its result is registered in tq_ctrl
// and then handed to the output register.
// A clear to send reads the entries from the oldest one, one per cycle, and
// takes the first whose send time is zero or not later than now_ms. Entries
// behind it are then moved up one place, one per cycle, through the single
// entry memory. A clear to send thus works through the entries held in the
// queue one at a time, as the single read port and single write port of that
// memory allow.
// One request is in work at a time; the next is accepted as soon as the
// previous result has been handed to the output register.
// Reset empties the queue at once; entry contents are not cleared.
// When the receiver stalls, the output register holds its result; one more
// request can be accepted and worked on, then s_tready stays low until the
// register frees up.
module timed_transmit_queue #(
    parameter int QUEUE_DEPTH = tq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] now_ms, [39:32] msg_type, [71:40] send_time, [74:72] payload_length,
    // [82:75] payload_byte0, [90:83] payload_byte1, [98:91] payload_byte2,
    // [106:99] payload_byte3, [111:107] zero
    input  logic [tq_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] overflow_dropped, [8:1] out_type, [11:9] out_length, [19:12] out_byte0,
    // [27:20] out_byte1, [35:28] out_byte2, [43:36] out_byte3, [47:44] zero
    output logic [tq_pkg::OUT_DATA_W-1:0] m_tdata,
    // [1:0] result_kind
    output logic [1:0]                    m_tuser
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    tq_pkg::req_t    req;
    tq_pkg::result_t res;
    tq_pkg::result_t out_reg;
    logic            out_valid_reg;
    logic            push;
    logic            out_free;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    tq_pkg::entry_t  mem_wdata;
    tq_pkg::entry_t  mem_rdata;

    always_comb
    begin
        req.operation = s_tuser[0];
        req.now_ms = s_tdata[31:0];
        req.msg_type = s_tdata[39:32];
        req.send_time = s_tdata[71:40];
        req.payload_length = s_tdata[74:72];
        req.payload_bytes[0] = s_tdata[82:75];
        req.payload_bytes[1] = s_tdata[90:83];
        req.payload_bytes[2] = s_tdata[98:91];
        req.payload_bytes[3] = s_tdata[106:99];
    end

    tq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req       (req),
        .push      (push),
        .out_free  (out_free),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && out_free)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_reg.kind;
    assign m_tdata = {4'h0, out_reg.out_bytes[3], out_reg.out_bytes[2],
                      out_reg.out_bytes[1], out_reg.out_bytes[0],
                      out_reg.out_length, out_reg.out_type, out_reg.dropped};

endmodule

// ===== sv/tq_mem.sv =====
module tq_mem #(
    parameter int DEPTH = tq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  tq_pkg::entry_t  wdata,
    input  logic [AW-1:0]   raddr,
    output tq_pkg::entry_t  rdata
);

    tq_pkg::entry_t ram [DEPTH];
    tq_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
        rdata_reg <= ram[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tq_ctrl.sv =====
module tq_ctrl #(
    parameter int DEPTH = tq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tq_pkg::req_t     req,
    output logic             push,
    input  logic             out_free,
    output tq_pkg::result_t  res,
    output logic             mem_we,
    output logic [AW-1:0]    mem_waddr,
    output tq_pkg::entry_t   mem_wdata,
    output logic [AW-1:0]    mem_raddr,
    input  tq_pkg::entry_t   mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [31:0]     now_reg, now_next;
    tq_pkg::result_t res_reg, res_next;

    logic [2:0]      len_sat;
    tq_pkg::entry_t  new_entry;
    logic [CW-1:0]   idx_p1, idx_p2;

    // Physical slot of a queue position counted from the head.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH))
        begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign idx_p1 = idx_reg + CW'(1);
    assign idx_p2 = idx_reg + CW'(2);

    always_comb
    begin
        len_sat = (req.payload_length > tq_pkg::PAYLOAD_LIMIT) ?
                  tq_pkg::PAYLOAD_LIMIT : req.payload_length;
        new_entry.send_time = req.send_time;
        new_entry.msg_type = req.msg_type;
        new_entry.length = len_sat;
        for (int b = 0; b < tq_pkg::OUT_BYTES; b++)
        begin
            new_entry.payload[b] = (3'(b) < len_sat) ? req.payload_bytes[b] : 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        now_next = now_reg;
        res_next = res_reg;
        in_ready = 1'b0;
        push = 1'b0;
        mem_we = 1'b0;
        mem_waddr = head_reg;
        mem_wdata = new_entry;
        mem_raddr = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req.operation == tq_pkg::OP_ENQUEUE)
                    begin
                        mem_we = 1'b1;
                        res_next = '0;
                        res_next.kind = tq_pkg::KIND_ACK;
                        if (count_reg == CW'(DEPTH))
                        begin
                            // Full: the new entry takes the oldest slot.
                            mem_waddr = head_reg;
                            head_next = slot_of(head_reg, CW'(1));
                            res_next.dropped = 1'b1;
                        end
                        else
                        begin
                            mem_waddr = slot_of(head_reg, count_reg);
                            count_next = count_reg + CW'(1);
                        end
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        now_next = req.now_ms;
                        idx_next = '0;
                        if (count_reg == '0)
                        begin
                            res_next = '0;
                            res_next.kind = tq_pkg::KIND_NONE;
                            state_next = ST_PUSH;
                        end
                        else
                        begin
                            mem_raddr = head_reg;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                mem_raddr = slot_of(head_reg, idx_p1);
                if (mem_rdata.send_time <= now_reg)
                begin
                    res_next.kind = tq_pkg::KIND_SENT;
                    res_next.dropped = 1'b0;
                    res_next.out_type = mem_rdata.msg_type;
                    res_next.out_length = mem_rdata.length;
                    res_next.out_bytes = mem_rdata.payload;
                    if (idx_reg == '0)
                    begin
                        head_next = slot_of(head_reg, CW'(1));
                        count_next = count_reg - CW'(1);
                        state_next = ST_PUSH;
                    end
                    else if (idx_p1 == count_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        state_next = ST_SHIFT;
                    end
                end
                else if (idx_p1 == count_reg)
                begin
                    res_next = '0;
                    res_next.kind = tq_pkg::KIND_NONE;
                    state_next = ST_PUSH;
                end
                else
                begin
                    idx_next = idx_p1;
                end
            end

            ST_SHIFT:
            begin
                // Read data holds the entry one place behind the write slot.
                mem_we = 1'b1;
                mem_waddr = slot_of(head_reg, idx_reg);
                mem_wdata = mem_rdata;
                mem_raddr = slot_of(head_reg, idx_p2);
                if (idx_p2 == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_PUSH;
                end
                else
                begin
                    idx_next = idx_p1;
                end
            end

            ST_PUSH:
            begin
                push = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg <= '0;
            count_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== sv/tq_checker.sv =====
`include "assert_macros.svh"

module tq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tq_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser
);

    `TQ_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `TQ_ASSERT(a_kind_legal, clk, rst_n,
        !m_tvalid || m_tuser == tq_pkg::KIND_ACK || m_tuser == tq_pkg::KIND_SENT || m_tuser == tq_pkg::KIND_NONE,
        "illegal result kind")

    `TQ_ASSERT(a_ack_clean, clk, rst_n,
        !(m_tvalid && m_tuser == tq_pkg::KIND_ACK) || m_tdata[47:1] == '0,
        "enqueue result carries message fields")

    `TQ_ASSERT(a_none_clean, clk, rst_n,
        !(m_tvalid && m_tuser == tq_pkg::KIND_NONE) || m_tdata == '0,
        "nothing-to-send result is not all zero")

    `TQ_ASSERT(a_sent_shape, clk, rst_n,
        !(m_tvalid && m_tuser == tq_pkg::KIND_SENT) || (!m_tdata[0] && m_tdata[11:9] <= tq_pkg::PAYLOAD_LIMIT),
        "sent message has drop flag or oversized length")

endmodule

bind timed_transmit_queue tq_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import tq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    // A clear to send can walk and compact the whole queue; give it that long and more.
    localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
    localparam int ITEMS_PER_PHASE = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    // Requests waiting to be driven, the results they are predicted to give,
    // and the shadow copy of the transmit queue, oldest entry first.
    req_t    pending_requests[$];
    result_t expected_results[$];
    entry_t  shadow_queue[$];

    // Percentage of cycles in which the sender or the receiver holds back.
    int send_idle_pct = 31;
    int recv_idle_pct = 47;
    int fail_count = 0;

    always #4 clk = ~clk;

    timed_transmit_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Applies one accepted request to the shadow queue and returns the result
    // that the block has to give for it.
    function automatic result_t predict_transmit(input req_t req);
        result_t res;
        entry_t  ent;
        logic [2:0] len;
        int i;
        res = '0;
        if (req.operation == OP_ENQUEUE)
        begin
            // Oversized lengths saturate, and bytes past the length are stored as zero.
            len = (req.payload_length > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : req.payload_length;
            ent.send_time = req.send_time;
            ent.msg_type = req.msg_type;
            ent.length = len;
            for (i = 0; i < OUT_BYTES; i++)
            begin
                ent.payload[i] = (i < len) ? req.payload_bytes[i] : 8'h00;
            end
            // A full queue loses its oldest entry to make room.
            if (shadow_queue.size() == DEPTH)
            begin
                void'(shadow_queue.pop_front());
                res.dropped = 1'b1;
            end
            shadow_queue.insert(shadow_queue.size(), ent);
            res.kind = KIND_ACK;
            return res;
        end
        // Clear to send: the first entry, oldest first, whose time is zero or
        // not later than now (plain unsigned compare, no wrap) goes out.
        res.kind = KIND_NONE;
        for (i = 0; i < shadow_queue.size(); i++)
        begin
            if (shadow_queue[i].send_time == 32'd0 || shadow_queue[i].send_time <= req.now_ms)
            begin
                res.kind = KIND_SENT;
                res.out_type = shadow_queue[i].msg_type;
                res.out_length = shadow_queue[i].length;
                res.out_bytes = shadow_queue[i].payload;
                shadow_queue.delete(i);
                return res;
            end
        end
        return res;
    endfunction

    task automatic queue_request(input logic op, input logic [31:0] now,
                                 input logic [7:0] mtype, input logic [31:0] stime,
                                 input logic [2:0] len, input logic [31:0] bytes);
        req_t req;
        req.operation = op;
        req.now_ms = now;
        req.msg_type = mtype;
        req.send_time = stime;
        req.payload_length = len;
        req.payload_bytes = bytes;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Request driver. A request that is offered stays offered until it is
    // taken; only between requests may the sender idle. The prediction is made
    // at the edge where the request is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.insert(expected_results.size(),
                                        predict_transmit(pending_requests[0]));
                void'(pending_requests.pop_front());
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_requests[0].operation;
                    s_tdata <= {5'b0, pending_requests[0].payload_bytes,
                                pending_requests[0].payload_length,
                                pending_requests[0].send_time,
                                pending_requests[0].msg_type,
                                pending_requests[0].now_ms};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. The receiver stalls at random; every accepted result is
    // checked field by field against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: kind 0x%0h data 0x%0h",
                       m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("result_kind", want.kind, m_tuser);
                compare_field("overflow_dropped", want.dropped, m_tdata[0]);
                compare_field("out_type", want.out_type, m_tdata[8:1]);
                compare_field("out_length", want.out_length, m_tdata[11:9]);
                compare_field("out_byte0", want.out_bytes[0], m_tdata[19:12]);
                compare_field("out_byte1", want.out_bytes[1], m_tdata[27:20]);
                compare_field("out_byte2", want.out_bytes[2], m_tdata[35:28]);
                compare_field("out_byte3", want.out_bytes[3], m_tdata[43:36]);
            end
        end
    end

    // Stimulus. A directed opening, then three random phases with different
    // idling, each built from bursts that lean toward filling the queue
    // (so overflow happens) or toward draining it (so nothing-to-send happens).
    initial
    begin
        int phase;
        int count;
        int burst_len;
        int enq_pct;
        int k;
        logic        op;
        logic [31:0] base;
        logic [31:0] stime;
        logic [31:0] now;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Clear to send on an empty queue.
        queue_request(OP_CTS, 32'd0, 8'h00, 32'd0, 3'd0, 32'h0);
        // Length zero hides all bytes; full length with the latest possible time.
        queue_request(OP_ENQUEUE, 32'd0, 8'h00, 32'd0, 3'd0, 32'hFFFF_FFFF);
        queue_request(OP_ENQUEUE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 3'd4, 32'hA5C3_3CA5);
        // Oversized lengths saturate to the four-byte limit.
        queue_request(OP_ENQUEUE, 32'd0, 8'h5A, 32'd100, 3'd7, 32'h8040_2010);
        queue_request(OP_ENQUEUE, 32'd0, 8'h3C, 32'd0, 3'd5, 32'hFFFF_FFFF);
        queue_request(OP_ENQUEUE, 32'd0, 8'h81, 32'd1, 3'd1, 32'hDEAD_BEEF);
        queue_request(OP_ENQUEUE, 32'd0, 8'h42, 32'd50, 3'd2, 32'h1234_5678);
        queue_request(OP_ENQUEUE, 32'd0, 8'h24, 32'd0, 3'd3, 32'hCAFE_F00D);
        // The scan skips entries that are not yet due and takes the first that is.
        queue_request(OP_CTS, 32'd0, 8'h00, 32'd0, 3'd0, 32'h0);
        queue_request(OP_CTS, 32'd99, 8'h00, 32'd0, 3'd0, 32'h0);
        queue_request(OP_CTS, 32'd0, 8'h00, 32'd0, 3'd0, 32'h0);
        queue_request(OP_CTS, 32'd49, 8'h00, 32'd0, 3'd0, 32'h0);
        queue_request(OP_CTS, 32'd99, 8'h00, 32'd0, 3'd0, 32'h0);
        queue_request(OP_CTS, 32'd99, 8'h00, 32'd0, 3'd0, 32'h0);
        // Equal times qualify; one below the largest time does not.
        queue_request(OP_CTS, 32'd100, 8'h00, 32'd0, 3'd0, 32'h0);
        queue_request(OP_CTS, 32'hFFFF_FFFE, 8'h00, 32'd0, 3'd0, 32'h0);
        queue_request(OP_CTS, 32'hFFFF_FFFF, 8'h00, 32'd0, 3'd0, 32'h0);
        queue_request(OP_CTS, 32'hFFFF_FFFF, 8'h00, 32'd0, 3'd0, 32'h0);

        // The sender holds off until every result of a part has come back.
        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(negedge clk);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 31;
                    recv_idle_pct = 47;
                end
                1:
                begin
                    send_idle_pct = 47;
                    recv_idle_pct = 31;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            count = 0;
            while (count < ITEMS_PER_PHASE)
            begin
                case ($urandom_range(0, 3))
                    0: enq_pct = 90;
                    1: enq_pct = 50;
                    2: enq_pct = 15;
                    default: enq_pct = 70;
                endcase
                burst_len = $urandom_range(8, 40);
                // Times in a burst cluster around one base so that compares go both ways.
                base = $urandom;
                for (k = 0; k < burst_len; k++)
                begin
                    op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_CTS;
                    case ($urandom_range(0, 3))
                        0: stime = 32'd0;
                        1: stime = $urandom;
                        default: stime = base + $urandom_range(0, 300);
                    endcase
                    case ($urandom_range(0, 5))
                        0: now = $urandom;
                        1: now = 32'd0;
                        2: now = 32'hFFFF_FFFF;
                        default: now = base + $urandom_range(0, 300);
                    endcase
                    queue_request(op, now, 8'($urandom), stime, 3'($urandom), $urandom);
                    count++;
                end
            end
            while (pending_requests.size() != 0 || expected_results.size() != 0)
                @(negedge clk);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS timed_transmit_queue");
        else
            $display("FAIL timed_transmit_queue");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("FAIL timed_transmit_queue");
        $finish;
    end

endmodule
